FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion clocked on clk, off while reset is low
`define BLS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// assertion clocked on clk, also active around reset
`define BLS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: src/bls_pkg.sv
// ---------------------------------------------------------------------------
// bls_pkg
// shared types and constants of the line stepper
// ---------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

    localparam int DIM_BITS    = 13;
    localparam int STRIDE_BITS = 14;
    localparam int ADDR_BITS   = 25;
    localparam int COLOR_BITS  = 24;
    localparam int PROD_BITS   = DIM_BITS + STRIDE_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = STRIDE_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FB_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FB_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_STRIDE = 2'd2;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [DIM_BITS-1:0]    RST_FB_WIDTH   = 13'd1024;
    localparam logic [DIM_BITS-1:0]    RST_FB_HEIGHT  = 13'd768;
    localparam logic [STRIDE_BITS-1:0] RST_ROW_STRIDE = 14'd1024;

    typedef struct packed {
        logic [DIM_BITS-1:0]    fb_width;
        logic [DIM_BITS-1:0]    fb_height;
        logic [STRIDE_BITS-1:0] row_stride;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/bresenham_line_stepper.sv
// ---------------------------------------------------------------------------
// bresenham_line_stepper
// line rasterizer, one point out for each start or step request
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  request   req_valid/req_ready    req_type, start_x/y, stop_x/y, line_color
//  result    res_valid/res_ready    point_x/y, visible, pixel_addr,
//                                   pixel_color, done_res
//  config    cfg_wr_en              cfg_addr, cfg_wdata
//
//  one request per cycle while no stalled result holds back the line state;
//  each result passes through the line state register and the result register
//  the pixel address multiplier sits between those two registers
//  reset clears the line state to a finished line at (0,0), color 0
//  a stalled result holds while one more request is taken into the line state
// ---------------------------------------------------------------------------
`default_nettype none

module bresenham_line_stepper #(
    parameter int COORD_BITS = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     cfg_wr_en,
    input  wire [bls_pkg::CFG_IDX_BITS-1:0]         cfg_addr,
    input  wire [bls_pkg::CFG_DATA_BITS-1:0]        cfg_wdata,
    input  wire                                     req_valid,
    output logic                                    req_ready,
    input  wire                                     req_type,
    input  wire signed [COORD_BITS-1:0]             start_x,
    input  wire signed [COORD_BITS-1:0]             start_y,
    input  wire signed [COORD_BITS-1:0]             stop_x,
    input  wire signed [COORD_BITS-1:0]             stop_y,
    input  wire [bls_pkg::COLOR_BITS-1:0]           line_color,
    output logic                                    res_valid,
    input  wire                                     res_ready,
    output logic signed [COORD_BITS-1:0]            point_x,
    output logic signed [COORD_BITS-1:0]            point_y,
    output logic                                    visible,
    output logic [bls_pkg::ADDR_BITS-1:0]           pixel_addr,
    output logic [bls_pkg::COLOR_BITS-1:0]          pixel_color,
    output logic                                    done_res
);

    bls_pkg::cfg_t                  cfg_reg, cfg_next;

    logic                           pt_valid;
    logic                           pt_take;
    logic signed [COORD_BITS-1:0]   pt_x;
    logic signed [COORD_BITS-1:0]   pt_y;
    logic [bls_pkg::COLOR_BITS-1:0] pt_color;
    logic                           pt_done;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                bls_pkg::CFG_FB_WIDTH:   cfg_next.fb_width   = cfg_wdata[bls_pkg::DIM_BITS-1:0];
                bls_pkg::CFG_FB_HEIGHT:  cfg_next.fb_height  = cfg_wdata[bls_pkg::DIM_BITS-1:0];
                bls_pkg::CFG_ROW_STRIDE: cfg_next.row_stride = cfg_wdata;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fb_width   <= bls_pkg::RST_FB_WIDTH;
            cfg_reg.fb_height  <= bls_pkg::RST_FB_HEIGHT;
            cfg_reg.row_stride <= bls_pkg::RST_ROW_STRIDE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bls_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .start_x    (start_x),
        .start_y    (start_y),
        .stop_x     (stop_x),
        .stop_y     (stop_y),
        .line_color (line_color),
        .pt_valid   (pt_valid),
        .pt_take    (pt_take),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .pt_color   (pt_color),
        .pt_done    (pt_done)
    );

    bls_pixel_out #(
        .COORD_BITS (COORD_BITS)
    ) u_pixel_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pt_valid    (pt_valid),
        .pt_take     (pt_take),
        .pt_x        (pt_x),
        .pt_y        (pt_y),
        .pt_color    (pt_color),
        .pt_done     (pt_done),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .visible     (visible),
        .pixel_addr  (pixel_addr),
        .pixel_color (pixel_color),
        .done_res    (done_res)
    );

endmodule

`default_nettype wire

FILE: src/bls_stepper.sv
// ---------------------------------------------------------------------------
// bls_stepper
// line state and one error-rule step per accepted step request until the line is done
// ---------------------------------------------------------------------------
`default_nettype none

module bls_stepper #(
    parameter int COORD_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 req_valid,
    output logic                                req_ready,
    input  wire                                 req_type,
    input  wire signed [COORD_BITS-1:0]         start_x,
    input  wire signed [COORD_BITS-1:0]         start_y,
    input  wire signed [COORD_BITS-1:0]         stop_x,
    input  wire signed [COORD_BITS-1:0]         stop_y,
    input  wire [bls_pkg::COLOR_BITS-1:0]       line_color,
    output logic                                pt_valid,
    input  wire                                 pt_take,
    output logic signed [COORD_BITS-1:0]        pt_x,
    output logic signed [COORD_BITS-1:0]        pt_y,
    output logic [bls_pkg::COLOR_BITS-1:0]      pt_color,
    output logic                                pt_done
);

    localparam int SX_W  = COORD_BITS + 1;
    localparam int SY_W  = COORD_BITS + 2;
    localparam int ERR_W = COORD_BITS + 3;
    localparam int E2_W  = COORD_BITS + 4;
    localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    logic signed [COORD_BITS-1:0]   cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0]   cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0]   end_x_reg, end_x_next;
    logic signed [COORD_BITS-1:0]   end_y_reg, end_y_next;
    logic signed [SX_W-1:0]         span_x_reg, span_x_next;
    logic signed [SY_W-1:0]         neg_span_y_reg, neg_span_y_next;
    logic                           dir_x_neg_reg, dir_x_neg_next;
    logic                           dir_y_neg_reg, dir_y_neg_next;
    logic signed [ERR_W-1:0]        error_term_reg, error_term_next;
    logic [bls_pkg::COLOR_BITS-1:0] held_color_reg, held_color_next;
    logic                           line_done_reg, line_done_next;
    logic                           pt_valid_reg, pt_valid_next;

    logic                           accept;
    logic signed [SX_W-1:0]         dx;
    logic signed [SX_W-1:0]         dy;
    logic signed [SX_W-1:0]         abs_dx;
    logic signed [SX_W-1:0]         abs_dy;
    logic signed [E2_W-1:0]         e2;
    logic                           step_x;
    logic                           step_y;

    assign req_ready = !pt_valid_reg || pt_take;
    assign accept    = req_valid && req_ready;

    assign dx     = SX_W'(stop_x) - SX_W'(start_x);
    assign dy     = SX_W'(stop_y) - SX_W'(start_y);
    assign abs_dx = dx[SX_W-1] ? -dx : dx;
    assign abs_dy = dy[SX_W-1] ? -dy : dy;

    assign e2     = {error_term_reg, 1'b0};
    assign step_x = e2 >= E2_W'(neg_span_y_reg);
    assign step_y = e2 <= E2_W'(span_x_reg);

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        span_x_next     = span_x_reg;
        neg_span_y_next = neg_span_y_reg;
        dir_x_neg_next  = dir_x_neg_reg;
        dir_y_neg_next  = dir_y_neg_reg;
        error_term_next = error_term_reg;
        held_color_next = held_color_reg;
        line_done_next  = line_done_reg;
        if (accept)
        begin
            if (req_type == bls_pkg::REQ_START)
            begin
                cur_x_next      = start_x;
                cur_y_next      = start_y;
                end_x_next      = stop_x;
                end_y_next      = stop_y;
                span_x_next     = abs_dx;
                neg_span_y_next = -SY_W'(abs_dy);
                dir_x_neg_next  = !(start_x < stop_x);
                dir_y_neg_next  = !(start_y < stop_y);
                error_term_next = ERR_W'(abs_dx) - ERR_W'(abs_dy);
                held_color_next = line_color;
                line_done_next  = (start_x == stop_x) && (start_y == stop_y);
            end
            else if (!line_done_reg)
            begin
                if (step_x)
                begin
                    cur_x_next = dir_x_neg_reg ? cur_x_reg - ONE : cur_x_reg + ONE;
                end
                if (step_y)
                begin
                    cur_y_next = dir_y_neg_reg ? cur_y_reg - ONE : cur_y_reg + ONE;
                end
                error_term_next = error_term_reg
                    + (step_x ? ERR_W'(neg_span_y_reg) : ERR_W'(0))
                    + (step_y ? ERR_W'(span_x_reg) : ERR_W'(0));
                line_done_next = (cur_x_next == end_x_reg) && (cur_y_next == end_y_reg);
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            pt_valid_next = 1'b1;
        end
        else if (pt_take)
        begin
            pt_valid_next = 1'b0;
        end
        else
        begin
            pt_valid_next = pt_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            span_x_reg     <= '0;
            neg_span_y_reg <= '0;
            dir_x_neg_reg  <= 1'b0;
            dir_y_neg_reg  <= 1'b0;
            error_term_reg <= '0;
            held_color_reg <= '0;
            line_done_reg  <= 1'b1;
            pt_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            end_x_reg      <= end_x_next;
            end_y_reg      <= end_y_next;
            span_x_reg     <= span_x_next;
            neg_span_y_reg <= neg_span_y_next;
            dir_x_neg_reg  <= dir_x_neg_next;
            dir_y_neg_reg  <= dir_y_neg_next;
            error_term_reg <= error_term_next;
            held_color_reg <= held_color_next;
            line_done_reg  <= line_done_next;
            pt_valid_reg   <= pt_valid_next;
        end
    end

    assign pt_valid = pt_valid_reg;
    assign pt_x     = cur_x_reg;
    assign pt_y     = cur_y_reg;
    assign pt_color = held_color_reg;
    assign pt_done  = line_done_reg;

endmodule

`default_nettype wire

FILE: src/bls_pixel_out.sv
// ---------------------------------------------------------------------------
// bls_pixel_out
// visibility test, pixel address and the result register
// ---------------------------------------------------------------------------
`default_nettype none

module bls_pixel_out #(
    parameter int COORD_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire bls_pkg::cfg_t                  cfg,
    input  wire                                 pt_valid,
    output logic                                pt_take,
    input  wire signed [COORD_BITS-1:0]         pt_x,
    input  wire signed [COORD_BITS-1:0]         pt_y,
    input  wire [bls_pkg::COLOR_BITS-1:0]       pt_color,
    input  wire                                 pt_done,
    output logic                                res_valid,
    input  wire                                 res_ready,
    output logic signed [COORD_BITS-1:0]        point_x,
    output logic signed [COORD_BITS-1:0]        point_y,
    output logic                                visible,
    output logic [bls_pkg::ADDR_BITS-1:0]       pixel_addr,
    output logic [bls_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                done_res
);

    localparam int CW = (COORD_BITS > bls_pkg::STRIDE_BITS) ? COORD_BITS : bls_pkg::STRIDE_BITS;
    localparam int DB = bls_pkg::DIM_BITS;
    localparam int PB = bls_pkg::PROD_BITS;

    logic [CW-1:0]                  x_w;
    logic [CW-1:0]                  y_w;
    logic                           vis;
    logic [PB-1:0]                  row_base;
    logic [PB-1:0]                  lin_addr;

    logic                           res_valid_reg, res_valid_next;
    logic signed [COORD_BITS-1:0]   point_x_reg;
    logic signed [COORD_BITS-1:0]   point_y_reg;
    logic                           visible_reg;
    logic [bls_pkg::ADDR_BITS-1:0]  pixel_addr_reg;
    logic [bls_pkg::COLOR_BITS-1:0] pixel_color_reg;
    logic                           done_res_reg;

    assign pt_take = pt_valid && (!res_valid_reg || res_ready);

    assign x_w = CW'($unsigned(pt_x));
    assign y_w = CW'($unsigned(pt_y));
    assign vis = !pt_x[COORD_BITS-1] && !pt_y[COORD_BITS-1]
                 && (x_w < CW'(cfg.fb_width)) && (y_w < CW'(cfg.fb_height));

    // visible coordinates always fit the framebuffer dimension width
    assign row_base = PB'(y_w[DB-1:0]) * PB'(cfg.row_stride);
    assign lin_addr = row_base + PB'(x_w[DB-1:0]);

    always_comb
    begin
        if (pt_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_take)
        begin
            point_x_reg     <= pt_x;
            point_y_reg     <= pt_y;
            visible_reg     <= vis;
            pixel_addr_reg  <= vis ? lin_addr[bls_pkg::ADDR_BITS-1:0] : '0;
            pixel_color_reg <= pt_color;
            done_res_reg    <= pt_done;
        end
    end

    assign res_valid   = res_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign visible     = visible_reg;
    assign pixel_addr  = pixel_addr_reg;
    assign pixel_color = pixel_color_reg;
    assign done_res    = done_res_reg;

endmodule

`default_nettype wire

FILE: src/bls_checker.sv
// ---------------------------------------------------------------------------
// bls_checker
// port level checks of the line stepper, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bls_checker #(
    parameter int COORD_BITS = 16
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     req_valid,
    input  wire                                     req_ready,
    input  wire                                     res_valid,
    input  wire                                     res_ready,
    input  wire signed [COORD_BITS-1:0]             point_x,
    input  wire signed [COORD_BITS-1:0]             point_y,
    input  wire                                     visible,
    input  wire [bls_pkg::ADDR_BITS-1:0]            pixel_addr,
    input  wire [bls_pkg::COLOR_BITS-1:0]           pixel_color,
    input  wire                                     done_res
);

    logic                                                        res_stall;
    logic                                                        coord_neg;
    logic [2*COORD_BITS+bls_pkg::ADDR_BITS+bls_pkg::COLOR_BITS+1:0] res_word;

    assign res_stall = res_valid && !res_ready;
    assign coord_neg = point_x[COORD_BITS-1] || point_y[COORD_BITS-1];
    assign res_word  = {point_x, point_y, visible, pixel_addr, pixel_color, done_res};

    // stalled result holds
    `BLS_ASSERT(a_res_hold, clk, rst_n, res_stall |=> res_valid && $stable(res_word))

    // a request is always taken while no result is pending
    `BLS_ASSERT(a_req_free, clk, rst_n, !res_valid && req_valid |-> req_ready)

    // off-screen points carry a zero address
    `BLS_ASSERT(a_addr_zero, clk, rst_n, res_valid && !visible |-> pixel_addr == '0)

    // visible points never have negative coordinates
    `BLS_ASSERT(a_vis_pos, clk, rst_n, res_valid && visible |-> !coord_neg)

    // no result right out of reset
    `BLS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !res_valid)

endmodule

bind bresenham_line_stepper bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (.*);

`default_nettype wire

FILE: sim/bresenham_line_stepper_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bresenham_line_stepper_tb
// self-checking bench for the line rasterizer: a queue-fed driver presents
// start and step requests in random bursts, an in-bench line walker predicts
// every emitted point, and a monitor with its own stall pattern compares each
// point field by field across several framebuffer geometries
// ---------------------------------------------------------------------------

module bresenham_line_stepper_tb;

    localparam int CRD           = 16;
    localparam int PHASE_ITEMS   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES  = 8;

    localparam int COLOR_BITS    = bls_pkg::COLOR_BITS;
    localparam int ADDR_BITS     = bls_pkg::ADDR_BITS;
    localparam int CFG_IDX_BITS  = bls_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = bls_pkg::CFG_DATA_BITS;
    localparam int DIM_BITS      = bls_pkg::DIM_BITS;
    localparam int STRIDE_BITS   = bls_pkg::STRIDE_BITS;

    typedef struct packed {
        logic                  kind;
        logic [CRD-1:0]        x0, y0, x1, y1;
        logic [COLOR_BITS-1:0] color;
    } line_req_t;

    typedef struct packed {
        logic [CRD-1:0]        x, y;
        logic                  vis;
        logic [ADDR_BITS-1:0]  addr;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic                  req_type = bls_pkg::REQ_STEP;
    logic signed [CRD-1:0] start_x = '0;
    logic signed [CRD-1:0] start_y = '0;
    logic signed [CRD-1:0] stop_x = '0;
    logic signed [CRD-1:0] stop_y = '0;
    logic [COLOR_BITS-1:0] line_color = '0;

    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic signed [CRD-1:0] point_x;
    logic signed [CRD-1:0] point_y;
    logic                  visible;
    logic [ADDR_BITS-1:0]  pixel_addr;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  done_res;

    bresenham_line_stepper #(
        .COORD_BITS (CRD)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_type    (req_type),
        .start_x     (start_x),
        .start_y     (start_y),
        .stop_x      (stop_x),
        .stop_y      (stop_y),
        .line_color  (line_color),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .visible     (visible),
        .pixel_addr  (pixel_addr),
        .pixel_color (pixel_color),
        .done_res    (done_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the framebuffer registers
    bls_pkg::cfg_t fb_cfg = '{fb_width: bls_pkg::RST_FB_WIDTH,
                              fb_height: bls_pkg::RST_FB_HEIGHT,
                              row_stride: bls_pkg::RST_ROW_STRIDE};

    // line walker state
    logic signed [CRD-1:0]  walk_x = '0;
    logic signed [CRD-1:0]  walk_y = '0;
    logic signed [CRD-1:0]  goal_x = '0;
    logic signed [CRD-1:0]  goal_y = '0;
    logic signed [CRD:0]    run_x = '0;
    logic signed [CRD+1:0]  neg_run_y = '0;
    logic                   step_left = 1'b0;
    logic                   step_down = 1'b0;
    logic signed [CRD+2:0]  err_acc = '0;
    logic [COLOR_BITS-1:0]  hold_color = '0;
    logic                   walk_finished = 1'b1;

    line_req_t pending_reqs[$];
    point_t    expected_points[$];
    line_req_t cur_req;

    int queued_items  = 0;
    int sent_count    = 0;
    int lines_started = 0;
    int points_seen   = 0;
    int fail_count    = 0;
    int settings_seen = 0;
    int idle_cycles   = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int stall_mode    = 0;
    int beat_cnt      = 0;

    function automatic point_t walk_line(input line_req_t r);
        point_t                p;
        logic signed [CRD:0]   dx;
        logic signed [CRD:0]   dy;
        logic signed [CRD+3:0] e2;
        logic [31:0]           lin;
        if (r.kind == bls_pkg::REQ_START)
        begin
            walk_x = r.x0;
            walk_y = r.y0;
            goal_x = r.x1;
            goal_y = r.y1;
            dx = $signed({goal_x[CRD-1], goal_x}) - $signed({walk_x[CRD-1], walk_x});
            dy = $signed({goal_y[CRD-1], goal_y}) - $signed({walk_y[CRD-1], walk_y});
            run_x = (dx < 0) ? -dx : dx;
            dy = (dy < 0) ? -dy : dy;
            neg_run_y = -(CRD+2)'(dy);
            step_left = !(walk_x < goal_x);
            step_down = !(walk_y < goal_y);
            err_acc = (CRD+3)'(run_x) + (CRD+3)'(neg_run_y);
            hold_color = r.color;
            walk_finished = (walk_x == goal_x) && (walk_y == goal_y);
        end
        else if (!walk_finished)
        begin
            e2 = (CRD+4)'(err_acc);
            e2 = e2 <<< 1;
            if (e2 >= (CRD+4)'(neg_run_y))
            begin
                err_acc = err_acc + (CRD+3)'(neg_run_y);
                walk_x = step_left ? walk_x - CRD'(1) : walk_x + CRD'(1);
            end
            if (e2 <= (CRD+4)'(run_x))
            begin
                err_acc = err_acc + (CRD+3)'(run_x);
                walk_y = step_down ? walk_y - CRD'(1) : walk_y + CRD'(1);
            end
            walk_finished = (walk_x == goal_x) && (walk_y == goal_y);
        end
        p.x = walk_x;
        p.y = walk_y;
        p.vis = (walk_x >= 0) && (walk_y >= 0) &&
                (walk_x < $signed(CRD'(fb_cfg.fb_width))) &&
                (walk_y < $signed(CRD'(fb_cfg.fb_height)));
        lin = {16'b0, walk_y} * {18'b0, fb_cfg.row_stride} + {16'b0, walk_x};
        p.addr = p.vis ? lin[ADDR_BITS-1:0] : '0;
        p.color = hold_color;
        p.done = walk_finished;
        return p;
    endfunction

    function automatic line_req_t start_req(input int x0, input int y0, input int x1,
                                            input int y1, input int c);
        line_req_t r;
        r.kind = bls_pkg::REQ_START;
        r.x0 = CRD'(x0);
        r.y0 = CRD'(y0);
        r.x1 = CRD'(x1);
        r.y1 = CRD'(y1);
        r.color = COLOR_BITS'(c);
        return r;
    endfunction

    // step requests carry random junk in the unused fields
    function automatic line_req_t step_req();
        line_req_t r;
        r.kind = bls_pkg::REQ_STEP;
        r.x0 = CRD'($urandom);
        r.y0 = CRD'($urandom);
        r.x1 = CRD'($urandom);
        r.y1 = CRD'($urandom);
        r.color = COLOR_BITS'($urandom);
        return r;
    endfunction

    function automatic logic [CRD-1:0] pick_coord(input int lim);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return CRD'($urandom);
        else if (sel < 3)
            return CRD'(lim - 3 + int'($urandom_range(0, 6)));
        else
            return CRD'(int'($urandom_range(0, 96)) - 16);
    endfunction

    task automatic queue_line();
        line_req_t r;
        int        sel;
        int        dx;
        int        dy;
        int        span;
        int        n;
        r.kind = bls_pkg::REQ_START;
        r.x0 = pick_coord(int'(fb_cfg.fb_width));
        r.y0 = pick_coord(int'(fb_cfg.fb_height));
        sel = $urandom_range(0, 19);
        if (sel == 0)
        begin
            r.x1 = r.x0;
            r.y1 = r.y0;
        end
        else if (sel < 3)
        begin
            r.x1 = CRD'($urandom);
            r.y1 = CRD'($urandom);
        end
        else
        begin
            r.x1 = CRD'(int'($signed(r.x0)) + int'($urandom_range(0, 48)) - 24);
            r.y1 = CRD'(int'($signed(r.y0)) + int'($urandom_range(0, 48)) - 24);
        end
        r.color = COLOR_BITS'($urandom);
        pending_reqs.push_back(r);
        dx = int'($signed(r.x1)) - int'($signed(r.x0));
        dy = int'($signed(r.y1)) - int'($signed(r.y0));
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        span = (dx > dy) ? dx : dy;
        // short lines run to the end and past it, some get cut by a new start
        if (span <= 64)
        begin
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(0, span);
            else
                n = span + int'($urandom_range(0, 3));
        end
        else
            n = $urandom_range(1, 24);
        repeat (n)
            pending_reqs.push_back(step_req());
        queued_items += 1 + n;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_BITS'(val);
        case (idx)
            bls_pkg::CFG_FB_WIDTH:   fb_cfg.fb_width   = DIM_BITS'(val);
            bls_pkg::CFG_FB_HEIGHT:  fb_cfg.fb_height  = DIM_BITS'(val);
            bls_pkg::CFG_ROW_STRIDE: fb_cfg.row_stride = STRIDE_BITS'(val);
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_frame(input int w, input int h, input int s);
        write_reg(bls_pkg::CFG_FB_WIDTH, w);
        write_reg(bls_pkg::CFG_FB_HEIGHT, h);
        write_reg(bls_pkg::CFG_ROW_STRIDE, s);
        settings_seen++;
    endtask

    // sender holds off until every requested point has come back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_points.size() != 0);
    endtask

    // driver
    always @(posedge clk)
    begin
        point_t pt;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                pt = walk_line(cur_req);
                expected_points.push_back(pt);
                sent_count++;
                if (cur_req.kind == bls_pkg::REQ_START)
                    lines_started++;
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    req_valid  <= 1'b1;
                    req_type   <= cur_req.kind;
                    start_x    <= cur_req.x0;
                    start_y    <= cur_req.y0;
                    stop_x     <= cur_req.x1;
                    stop_y     <= cur_req.y1;
                    line_color <= cur_req.color;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor and result stall pattern
    always @(posedge clk)
    begin
        point_t want;
        logic   next_ready;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                points_seen++;
                if (expected_points.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected point x=%0d y=%0d at %0t", point_x, point_y,
                                 $realtime);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (point_x !== want.x || point_y !== want.y || visible !== want.vis ||
                        pixel_addr !== want.addr || pixel_color !== want.color ||
                        done_res !== want.done)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("point %0d mismatch at %0t", points_seen, $realtime);
                            $display("  expected x=%0d y=%0d vis=%0b addr=%h color=%h done=%0b",
                                     $signed(want.x), $signed(want.y), want.vis, want.addr,
                                     want.color, want.done);
                            $display("  actual   x=%0d y=%0d vis=%0b addr=%h color=%h done=%0b",
                                     point_x, point_y, visible, pixel_addr, pixel_color,
                                     done_res);
                        end
                    end
                end
            end
            if ((req_valid && req_ready) || (res_valid && res_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            beat_cnt = beat_cnt + 1;
            if (beat_cnt % 128 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: next_ready = 1'b1;
                1: next_ready = 1'($urandom_range(0, 1));
                2: next_ready = (beat_cnt % 4) != 3;
                default: next_ready = (beat_cnt % 16) < 4;
            endcase
            res_ready <= next_ready;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int ph;
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        @(negedge clk);
        // steps before any start, degenerate line, step after done
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(5, 5, 5, 5, 24'hFFFFFF));
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(0, 0, 4, 2, 24'h000000));
        repeat (5)
            pending_reqs.push_back(step_req());
        // framebuffer corner
        pending_reqs.push_back(start_req(1023, 767, 1024, 768, 24'hA5A5A5));
        pending_reqs.push_back(step_req());
        // coordinate extremes
        pending_reqs.push_back(start_req(-32768, -32768, 32767, 32767, 24'h5A5A5A));
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(32767, -32768, -32768, 32767, 24'hFFFFFF));
        pending_reqs.push_back(step_req());
        // steep and vertical lines
        pending_reqs.push_back(start_req(-3, 2, 1, 12, 24'h123456));
        repeat (3)
            pending_reqs.push_back(step_req());
        pending_reqs.push_back(start_req(10, -1, 10, 1, 24'h800001));
        pending_reqs.push_back(step_req());
        pending_reqs.push_back(step_req());
        queued_items += pending_reqs.size();
        drain();

        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_frame(1, 1, 1);
                1: set_frame(4096, 4096, 8192);
                2: set_frame(0, 0, 0);
                3: set_frame(8191, 8191, 16383);
                4: set_frame($urandom_range(1, 64), $urandom_range(1, 64),
                             $urandom_range(1, 8192));
                5: set_frame(640, 480, 640);
                default: set_frame($urandom_range(1, 4096), $urandom_range(1, 4096),
                                   $urandom_range(1, 8192));
            endcase
            @(negedge clk);
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target)
                queue_line();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests (%0d line starts) sent, %0d points checked",
                 sent_count, lines_started, points_seen);
        $display("%0d framebuffer settings incl. degenerate and oversized ones",
                 settings_seen + 1);
        if (fail_count == 0 && expected_points.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
